// ===== hw/rtl/a2sc_pkg.sv =====
// ----------------------------------------------------------------------------
// a2sc_pkg
// Constants, character tables and key lookup for the ASCII to set-1
// scancode translator.
// ----------------------------------------------------------------------------
package a2sc_pkg;

	localparam int TableEntries = 46;
	localparam int Populated    = 46;
	localparam int SearchDepth  = (TableEntries < Populated) ? TableEntries : Populated;

	localparam logic [7:0] ShiftMake  = 8'h2A;
	localparam logic [7:0] ShiftBreak = 8'hAA;
	localparam logic [7:0] BreakBit   = 8'h80;

	localparam logic [7:0] MakeCodes [Populated] = '{
		8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
		8'h0C,
		8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
		8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
		8'h26, 8'h29, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
		8'h33, 8'h34, 8'h35, 8'h56,
		8'h39, 8'h1C, 8'h0E, 8'h01
	};

	// 1..0 ' q..p a..k l \ z..m , . - < space CR BS ESC
	localparam logic [7:0] PlainChars [Populated] = '{
		8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
		8'h27,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
		8'h6C, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
		8'h2C, 8'h2E, 8'h2D, 8'h3C,
		8'h20, 8'h0D, 8'h08, 8'h1B
	};

	// ! " @ $ % & / ( ) = ? Q..P A..K L | Z..M ; : _ > space LF BS ESC
	localparam logic [7:0] ShiftedChars [Populated] = '{
		8'h21, 8'h22, 8'h40, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28, 8'h29, 8'h3D,
		8'h3F,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
		8'h4C, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
		8'h3B, 8'h3A, 8'h5F, 8'h3E,
		8'h20, 8'h0A, 8'h08, 8'h1B
	};

	typedef struct packed {
		logic       hit;
		logic       need_shift;
		logic [7:0] make;
	} a2sc_key_t;

	// Lowest index wins in each table; the plain table wins over the shifted one.
	function automatic a2sc_key_t lookup(input logic [7:0] c);
		a2sc_key_t  k;
		logic       plain_hit;
		logic       shift_hit;
		logic [7:0] plain_code;
		logic [7:0] shift_code;
		plain_hit  = 1'b0;
		shift_hit  = 1'b0;
		plain_code = '0;
		shift_code = '0;
		for (int i = SearchDepth - 1; i >= 0; i--) begin
			if (PlainChars[i] == c) begin
				plain_hit  = 1'b1;
				plain_code = MakeCodes[i];
			end
			if (ShiftedChars[i] == c) begin
				shift_hit  = 1'b1;
				shift_code = MakeCodes[i];
			end
		end
		k.hit        = plain_hit | shift_hit;
		k.need_shift = !plain_hit;
		k.make       = plain_hit ? plain_code : shift_code;
		return k;
	endfunction

endpackage

// ===== hw/rtl/a2sc_in_if.sv =====
// ----------------------------------------------------------------------------
// a2sc_in_if
// Character channel: one ASCII byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface a2sc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ascii_code;

	modport source (output valid, output ascii_code, input ready);
	modport sink (input valid, input ascii_code, output ready);
	modport monitor (input valid, input ascii_code, input ready);
endinterface

// ===== hw/rtl/a2sc_out_if.sv =====
// ----------------------------------------------------------------------------
// a2sc_out_if
// Scancode channel: one set-1 scancode per word plus end-of-run flag.
// ----------------------------------------------------------------------------
interface a2sc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] scancode;
	logic       last_of_run;

	modport source (output valid, output scancode, output last_of_run, input ready);
	modport sink (input valid, input scancode, input last_of_run, output ready);
	modport monitor (input valid, input scancode, input last_of_run, input ready);
endinterface

// ===== hw/rtl/ascii_to_scancode_with_shift.sv =====
// ----------------------------------------------------------------------------
// ascii_to_scancode_with_shift
// Translates typed ASCII bytes into PC set-1 scancode runs, tracking shift.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one ASCII byte per word; codes returns scancodes, one word
//   per cycle while codes.ready is high. A known byte gives a run of two or
//   three words: an optional shift make (0x2A) or break (0xAA), the key make
//   code, and the key break code (make | 0x80) flagged last_of_run. Unknown
//   bytes give no words and leave the shift state unchanged.
//   Path: a taken byte goes to the input register, is looked up there, and
//   its run loads into the run register, from which its first word leaves.
//   Bytes are taken no faster than their runs drain, set by the single-word
//   output port draining the run register. The next byte is taken and looked
//   up while the current run drains, and its run loads in the cycle the last
//   word of the current run leaves.
//   Reset: shift released, both registers empty.
//   Stall: with codes.ready low the head word holds; once the input register
//   holds a known byte as well, chars.ready drops.
// ----------------------------------------------------------------------------
module ascii_to_scancode_with_shift (
	input  logic clk,
	input  logic arst_n,
	a2sc_in_if.sink    chars,
	a2sc_out_if.source codes
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	a2sc_pkg::a2sc_key_t key;

	logic              shift_held_q;
	logic [1:0]        run_cnt_q;
	logic [7:0]        run_q [3];

	logic              take;
	logic              can_load;
	logic              load;
	logic              adv_s1;
	logic              shift_change;

	assign key          = a2sc_pkg::lookup(byte_s1);
	assign take         = codes.valid && codes.ready;
	assign can_load     = (run_cnt_q == 2'd0) || (run_cnt_q == 2'd1 && take);
	assign load         = valid_s1 && key.hit && can_load;
	// unknown bytes are dropped straight from the input register
	assign adv_s1       = valid_s1 && (!key.hit || can_load);
	assign shift_change = key.need_shift != shift_held_q;

	assign chars.ready       = !valid_s1 || adv_s1;
	assign codes.valid       = run_cnt_q != 2'd0;
	assign codes.scancode    = run_q[0];
	assign codes.last_of_run = run_cnt_q == 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			byte_s1 <= chars.ascii_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_held_q <= 1'b0;
			run_cnt_q    <= 2'd0;
		end else if (load) begin
			shift_held_q <= key.need_shift;
			run_cnt_q    <= shift_change ? 2'd3 : 2'd2;
		end else if (take) begin
			run_cnt_q    <= run_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (shift_change) begin
				run_q[0] <= key.need_shift ? a2sc_pkg::ShiftMake : a2sc_pkg::ShiftBreak;
				run_q[1] <= key.make;
				run_q[2] <= key.make | a2sc_pkg::BreakBit;
			end else begin
				run_q[0] <= key.make;
				run_q[1] <= key.make | a2sc_pkg::BreakBit;
				run_q[2] <= run_q[2];
			end
		end else if (take) begin
			run_q[0] <= run_q[1];
			run_q[1] <= run_q[2];
		end
	end

endmodule

// ===== hw/rtl/a2sc_checker.sv =====
// ----------------------------------------------------------------------------
// a2sc_checker
// Port-level checks on the scancode translator, bound to every instance of it.
// ----------------------------------------------------------------------------
module a2sc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       chars_ready,
	input logic       codes_valid,
	input logic       codes_ready,
	input logic [7:0] codes_scancode,
	input logic       codes_last_of_run
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		codes_valid && !codes_ready |=>
			codes_valid && $stable(codes_scancode) && $stable(codes_last_of_run))
		else $error("stalled scancode word changed");

	// a run always ends on a key break
	a_last_break: assert property (@(posedge clk) disable iff (!arst_n)
		codes_valid && codes_last_of_run |-> codes_scancode[7])
		else $error("last word of run is not a break code");

	// the only non-final break code is shift break
	a_mid_break: assert property (@(posedge clk) disable iff (!arst_n)
		codes_valid && !codes_last_of_run && codes_scancode[7] |->
			codes_scancode == a2sc_pkg::ShiftBreak)
		else $error("unexpected break code inside run");

	// key make is followed at once by its own break, closing the run
	a_make_break: assert property (@(posedge clk) disable iff (!arst_n)
		codes_valid && codes_ready && !codes_last_of_run &&
		codes_scancode != a2sc_pkg::ShiftMake && codes_scancode != a2sc_pkg::ShiftBreak |=>
			codes_valid && codes_last_of_run &&
			codes_scancode == ($past(codes_scancode) | a2sc_pkg::BreakBit))
		else $error("key make not followed by matching break");

	// with no run pending the character side never stalls
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!codes_valid |-> chars_ready)
		else $error("character channel stalled with no run pending");

endmodule

bind ascii_to_scancode_with_shift a2sc_checker u_a2sc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.chars_ready       (chars.ready),
	.codes_valid       (codes.valid),
	.codes_ready       (codes.ready),
	.codes_scancode    (codes.scancode),
	.codes_last_of_run (codes.last_of_run)
);

// ===== bench/tb_ascii_to_scancode_with_shift.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_to_scancode_with_shift
// Drives ASCII bytes into the translator and checks every scancode word
// against its directed row or an in-bench translation with its own shift
// state. A short directed table comes first, then random bytes, mostly known
// characters. Both channels idle at random; once the scancode side holds off
// for a long stretch so that the block backs up into the character channel.
// ----------------------------------------------------------------------------
module tb_ascii_to_scancode_with_shift;

	localparam int RandomChars = 85;
	localparam int CycleLimit  = 50000;
	localparam int HoldCycles  = 100;
	localparam int DirectedRows = 25;

	typedef struct packed {
		logic [7:0] scancode;
		logic       last_of_run;
	} scan_word_t;

	// typed = 1: the expected run is given in the row, else translate_char decides
	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		logic [1:0] n;
		logic [7:0] s0;
		logic [7:0] s1;
		logic [7:0] s2;
	} char_row_t;

	logic clk;
	logic arst_n;

	a2sc_in_if  chars_if ();
	a2sc_out_if codes_if ();

	ascii_to_scancode_with_shift dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.codes  (codes_if.source)
	);

	scan_word_t pending_codes [$];
	logic       shift_down;
	int         chars_taken;
	int         errors;
	int         cycles;
	bit         hold_done;

	char_row_t char_rows [DirectedRows] = '{
		'{8'h61, 1'b1, 2'd2, 8'h1E, 8'h9E, 8'h00},                 // 'a' right after reset
		'{8'h00, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},                 // unknown, low extreme
		'{8'hFF, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},                 // unknown, high extreme
		'{8'h41, 1'b1, 2'd3, a2sc_pkg::ShiftMake, 8'h1E, 8'h9E},   // 'A'
		'{8'h20, 1'b1, 2'd3, a2sc_pkg::ShiftBreak, 8'h39, 8'hB9},  // space: plain table wins
		'{8'h21, 1'b1, 2'd3, a2sc_pkg::ShiftMake, 8'h02, 8'h82},   // '!'
		'{8'h1B, 1'b1, 2'd3, a2sc_pkg::ShiftBreak, 8'h01, 8'h81},  // escape releases shift
		'{8'h0A, 1'b1, 2'd3, a2sc_pkg::ShiftMake, 8'h1C, 8'h9C},   // newline needs shift
		'{8'h0D, 1'b1, 2'd3, a2sc_pkg::ShiftBreak, 8'h1C, 8'h9C},  // carriage return does not
		'{8'h08, 1'b1, 2'd2, 8'h0E, 8'h8E, 8'h00},                 // backspace
		'{8'h51, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},                 // 'Q'
		'{8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},                 // unknown while shifted
		'{8'h57, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},                 // 'W', shift still held
		'{8'h08, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},                 // backspace while shifted
		'{8'h7C, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h5C, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h3F, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h27, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h3E, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h3B, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h6D, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h7F, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h5F, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{8'h30, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// no idling on either side over this span of characters
	function automatic bit quiet_span();
		return chars_taken >= 50 && chars_taken < 85;
	endfunction

	// Plain table first, lowest index first; then the shifted table.
	function automatic void translate_char(input logic [7:0] c, input bit queue_it);
		int         idx;
		bit         want_shift;
		logic [7:0] make;
		idx = -1;
		want_shift = 1'b0;
		for (int i = 0; i < a2sc_pkg::TableEntries && i < a2sc_pkg::Populated; i++)
			if (idx < 0 && a2sc_pkg::PlainChars[i] == c)
				idx = i;
		if (idx < 0) begin
			for (int i = 0; i < a2sc_pkg::TableEntries && i < a2sc_pkg::Populated; i++)
				if (idx < 0 && a2sc_pkg::ShiftedChars[i] == c)
					idx = i;
			want_shift = 1'b1;
		end
		if (idx < 0)
			return;
		make = a2sc_pkg::MakeCodes[idx];
		if (want_shift != shift_down) begin
			if (queue_it)
				pending_codes.push_back('{want_shift ? a2sc_pkg::ShiftMake :
					a2sc_pkg::ShiftBreak, 1'b0});
			shift_down = want_shift;
		end
		if (queue_it) begin
			pending_codes.push_back('{make, 1'b0});
			pending_codes.push_back('{make | a2sc_pkg::BreakBit, 1'b1});
		end
	endfunction

	// Entered in the time step of a rising edge; returns in the step the byte is taken.
	task automatic send_char(input logic [7:0] c);
		while (!quiet_span() && $urandom_range(99) < 8) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid      <= 1'b1;
		chars_if.ascii_code <= c;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		chars_taken++;
	endtask

	function automatic logic [7:0] random_char();
		int idx;
		idx = $urandom_range(a2sc_pkg::Populated - 1);
		if ($urandom_range(99) < 20)
			return 8'($urandom_range(255));
		return $urandom_range(1) ? a2sc_pkg::ShiftedChars[idx] : a2sc_pkg::PlainChars[idx];
	endfunction

	initial begin
		logic [7:0] c;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ascii_code = '0;
		shift_down = 1'b0;
		chars_taken = 0;
		errors = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (char_rows[r]) begin
			send_char(char_rows[r].ch);
			if (char_rows[r].typed) begin
				if (char_rows[r].n == 2'd3)
					pending_codes.push_back('{char_rows[r].s0, 1'b0});
				if (char_rows[r].n != 2'd0) begin
					pending_codes.push_back('{char_rows[r].n == 2'd3 ?
						char_rows[r].s1 : char_rows[r].s0, 1'b0});
					pending_codes.push_back('{char_rows[r].n == 2'd3 ?
						char_rows[r].s2 : char_rows[r].s1, 1'b1});
				end
				translate_char(char_rows[r].ch, 1'b0);
			end else begin
				translate_char(char_rows[r].ch, 1'b1);
			end
		end

		for (int k = 0; k < RandomChars; k++) begin
			c = random_char();
			send_char(c);
			translate_char(c, 1'b1);
		end
		chars_if.valid <= 1'b0;

		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0 && pending_codes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// scancode side: random stalls, one long hold-off to back up the block
	initial begin
		codes_if.ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && chars_taken >= 30) begin
				hold_done = 1'b1;
				codes_if.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			codes_if.ready <= quiet_span() || $urandom_range(99) >= 8;
		end
	end

	always @(posedge clk) begin
		scan_word_t want;
		if (arst_n && codes_if.valid && codes_if.ready) begin
			if (pending_codes.size() == 0) begin
				$error("unexpected word: scancode %h last_of_run %b",
					codes_if.scancode, codes_if.last_of_run);
				errors++;
			end else begin
				want = pending_codes.pop_front();
				if (codes_if.scancode !== want.scancode) begin
					$error("scancode: expected %h, got %h", want.scancode, codes_if.scancode);
					errors++;
				end
				if (codes_if.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b",
						want.last_of_run, codes_if.last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
